### rtl/kpca_pkg.sv
// Shared constants and types for the keyed packet check word generator.
// Used by kpca_mix and keyed_packet_check_append; depends on nothing.
package kpca_pkg;

    localparam int unsigned LENGTH_BITS_DEF = 16;
    localparam int unsigned WORD_W          = 32;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned PLEN_W          = 16;

    localparam logic [WORD_W-1:0] SEED_EVEN      = 32'h1324_3546;
    localparam logic [WORD_W-1:0] SEED_ODD       = 32'h9878_6756;
    localparam logic [BYTE_W-1:0] BYTE_BIAS      = 8'd75;
    localparam logic [BYTE_W-1:0] RESTART_OPCODE = 8'd8;
    localparam logic [BYTE_W-1:0] ZERO_OPCODE    = 8'd0;

    typedef struct packed {
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] sum;
        logic              appended;
    } t_fin;

endpackage

### rtl/keyed_packet_check_append.sv
// Top level of the keyed packet check word generator.
// Depends on kpca_pkg and kpca_mix.
//
// Packet bytes enter on the s_axis side, one per transfer, with tlast on the final byte; the
// block takes one byte every cycle unless held off by the output side. Each packet yields one
// m_axis transfer: byte sum, length and running key are registered when its last byte is taken,
// then the byte-wise multiply mix is registered for output. tuser flags whether a check word is
// appended (clear when the opcode byte was zero, with a zero check word). The length saturates
// at 2^LENGTH_BITS-1; the key persists across packets and is cleared by opcode 8.
module keyed_packet_check_append import kpca_pkg::*; #(
    parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [BYTE_W-1:0]        s_axis_tdata,   // [7:0] data_byte
    input  logic                     s_axis_tlast,   // last_byte
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [WORD_W+PLEN_W-1:0] m_axis_tdata,   // [31:0] check_word, [47:32] packet_length
    output logic                     m_axis_tuser    // appended
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    logic [WORD_W-1:0]      r_key, n_key;
    logic [WORD_W-1:0]      r_sum, n_sum;
    logic [LENGTH_BITS-1:0] r_cnt, n_cnt;
    logic                   r_op_zero, n_op_zero;
    logic                   r_op_restart, n_op_restart;

    logic                   r_fin_valid;
    t_fin                   r_fin, n_fin;
    logic [LENGTH_BITS-1:0] r_fin_len;

    logic                   r_out_valid;
    logic [WORD_W-1:0]      r_out_word;
    logic [PLEN_W-1:0]      r_out_len;
    logic                   r_out_app;

    logic                   in_xfer;
    logic                   out_ready;
    logic                   fin_ready;
    logic                   first;
    logic [LENGTH_BITS-1:0] cnt_inc;
    logic [WORD_W-1:0]      key_new;
    logic [WORD_W-1:0]      mix_word;

    assign out_ready     = !r_out_valid || m_axis_tready;
    assign fin_ready     = !r_fin_valid || out_ready;
    assign s_axis_tready = fin_ready;
    assign in_xfer       = s_axis_tvalid && fin_ready;

    assign first   = (r_cnt == '0);
    assign cnt_inc = (r_cnt == LEN_MAX) ? r_cnt : r_cnt + 1'b1;

    always_comb begin
        n_op_zero    = first ? (s_axis_tdata == ZERO_OPCODE)    : r_op_zero;
        n_op_restart = first ? (s_axis_tdata == RESTART_OPCODE) : r_op_restart;
        n_sum        = r_sum + WORD_W'(s_axis_tdata);
        n_cnt        = cnt_inc;
        key_new      = (n_op_restart ? '0 : r_key) + 1'b1;
        n_key        = n_op_zero ? r_key : key_new + WORD_W'(cnt_inc);
        n_fin.key      = key_new;
        n_fin.sum      = n_sum;
        n_fin.appended = !n_op_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key        <= '0;
            r_sum        <= '0;
            r_cnt        <= '0;
            r_op_zero    <= 1'b0;
            r_op_restart <= 1'b0;
        end else if (in_xfer) begin
            if (s_axis_tlast) begin
                r_key        <= n_key;
                r_sum        <= '0;
                r_cnt        <= '0;
                r_op_zero    <= 1'b0;
                r_op_restart <= 1'b0;
            end else begin
                r_sum        <= n_sum;
                r_cnt        <= n_cnt;
                r_op_zero    <= n_op_zero;
                r_op_restart <= n_op_restart;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (fin_ready) begin
            r_fin_valid <= in_xfer && s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && s_axis_tlast) begin
            r_fin     <= n_fin;
            r_fin_len <= cnt_inc;
        end
    end

    kpca_mix #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_mix (
        .i_fin  (r_fin),
        .i_len  (r_fin_len),
        .o_word (mix_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_fin_valid) begin
            r_out_word <= mix_word;
            r_out_len  <= PLEN_W'(r_fin_len);
            r_out_app  <= r_fin.appended;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_len, r_out_word};
    assign m_axis_tuser  = r_out_app;

    a_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[WORD_W-1:0] == '0)
        else $error("check word not zero without append");

    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && s_axis_tlast |=> r_cnt == '0 && r_sum == '0)
        else $error("packet state not cleared after last byte");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && !s_axis_tlast && r_cnt != LEN_MAX |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("byte count did not advance");

    a_key_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_xfer |=> $stable(r_key))
        else $error("running key changed without a transfer");

endmodule

### rtl/kpca_mix.sv
// Final mix of the check word: seed by key parity, byte-wise multiply, add key and length; zero when not appended.
// Depends on kpca_pkg.
module kpca_mix import kpca_pkg::*; #(
    parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  t_fin                   i_fin,
    input  logic [LENGTH_BITS-1:0] i_len,
    output logic [WORD_W-1:0]      o_word
);

    logic [WORD_W-1:0] seeded;
    logic [WORD_W-1:0] mixed;
    logic [WORD_W-1:0] len_ext;

    assign seeded  = (i_fin.key[0] ? SEED_ODD : SEED_EVEN) + i_fin.sum;
    assign len_ext = WORD_W'(i_len);

    always_comb begin
        logic [BYTE_W-1:0] biased;
        logic [BYTE_W-1:0] factor;
        mixed = '0;
        for (int n = 0; n < 4; n++) begin
            biased = seeded[BYTE_W*n +: BYTE_W] + BYTE_BIAS;
            factor = i_len[BYTE_W-1:0] + BYTE_W'(n) + i_fin.key[BYTE_W-1:0];
            mixed[BYTE_W*n +: BYTE_W] = BYTE_W'(biased * factor);
        end
    end

    assign o_word = i_fin.appended ? (mixed + i_fin.key + len_ext) : '0;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for keyed_packet_check_append: packet bytes in, one check word transfer per packet.
// Depends on kpca_pkg and the RTL top; expected words come from an in-bench predictor or the stimulus table.

module testbench;
    import kpca_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int HALF_PERIOD = CLK_PERIOD / 2;
    localparam logic [15:0] LEN_SAT = 16'hFFFF;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              app;
        logic [PLEN_W-1:0] len;
    } check_result_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              typed;
        check_result_t     want;
    } stim_row_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [BYTE_W-1:0]        s_axis_tdata = '0;   // [7:0] data_byte
    logic                     s_axis_tlast = 1'b0; // last_byte
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [WORD_W+PLEN_W-1:0] m_axis_tdata;        // [31:0] check_word, [47:32] packet_length
    logic                     m_axis_tuser;        // appended

    logic [WORD_W-1:0]  key_now = '0;
    logic [WORD_W-1:0]  sum_now = '0;
    logic [15:0]        count_now = '0;
    logic               op_zero_now = 1'b0;
    logic               op_restart_now = 1'b0;

    check_result_t pending_checks[$];
    logic          failed = 1'b0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_requests = 0;
    int            hold_served = 0;
    int            hold_left = 0;

    int idle_set[4]  = '{0, 86, 0, 17};
    int stall_set[4] = '{0, 0, 86, 17};

    stim_row_t stim_rows [0:22] = '{
        '{8'h00, 1'b1, 1'b1, '{32'h0, 1'b0, 16'd1}},
        '{8'h01, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h08, 1'b0, 1'b0, '0},
        '{8'h55, 1'b0, 1'b0, '0},
        '{8'hAA, 1'b1, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h80, 1'b1, 1'b1, '{32'h0, 1'b0, 16'd4}},
        '{8'h08, 1'b1, 1'b0, '0},
        '{8'h07, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'h02, 1'b0, 1'b0, '0},
        '{8'h04, 1'b0, 1'b0, '0},
        '{8'h08, 1'b0, 1'b0, '0},
        '{8'h10, 1'b0, 1'b0, '0},
        '{8'h20, 1'b0, 1'b0, '0},
        '{8'h40, 1'b0, 1'b0, '0},
        '{8'h80, 1'b1, 1'b0, '0},
        '{8'h09, 1'b1, 1'b0, '0}
    };

    keyed_packet_check_append u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic logic [WORD_W-1:0] mix_check_word(input logic [WORD_W-1:0] key,
                                                         input logic [15:0] len,
                                                         input logic [WORD_W-1:0] sum);
        logic [WORD_W-1:0] seeded;
        logic [WORD_W-1:0] mixed;
        logic [7:0]        b;
        logic [7:0]        f;
        logic [7:0]        p;
        seeded = (key[0] ? SEED_ODD : SEED_EVEN) + sum;
        mixed = '0;
        for (int n = 0; n < 4; n++) begin
            b = seeded[8*n +: 8];
            f = len[7:0] + n[7:0] + key[7:0];
            p = (b + BYTE_BIAS) * f;
            mixed[8*n +: 8] = p;
        end
        return mixed + key + {16'b0, len};
    endfunction

    function automatic void predict_byte(input logic [7:0] d, input logic last,
                                         output logic done, output check_result_t res);
        done = 1'b0;
        res = '0;
        if (count_now == 16'd0) begin
            op_zero_now = (d == ZERO_OPCODE);
            op_restart_now = (d == RESTART_OPCODE);
        end
        sum_now = sum_now + {24'b0, d};
        if (count_now != LEN_SAT) begin
            count_now = count_now + 16'd1;
        end
        if (last) begin
            done = 1'b1;
            res.len = count_now;
            if (!op_zero_now) begin
                if (op_restart_now) begin
                    key_now = '0;
                end
                key_now = key_now + 32'd1;
                res.word = mix_check_word(key_now, count_now, sum_now);
                res.app = 1'b1;
                key_now = key_now + {16'b0, count_now};
            end
            sum_now = '0;
            count_now = '0;
            op_zero_now = 1'b0;
            op_restart_now = 1'b0;
        end
    endfunction

    task automatic offer_byte(input logic [7:0] d, input logic last,
                              input logic typed, input check_result_t want);
        logic          done;
        check_result_t got;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_byte(d, last, done, got);
        if (done) begin
            pending_checks.push_back(typed ? want : got);
        end
    endtask

    task automatic send_packet(input int n);
        logic [7:0] opcode;
        int         pick;
        pick = $urandom_range(9);
        if (pick == 0) begin
            opcode = ZERO_OPCODE;
        end else if (pick == 1) begin
            opcode = RESTART_OPCODE;
        end else begin
            opcode = 8'($urandom_range(255));
        end
        for (int i = 0; i < n; i++) begin
            offer_byte((i == 0) ? opcode : 8'($urandom_range(255)), i == n - 1, 1'b0, '0);
        end
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_checks.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        check_result_t got;
        check_result_t exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.word = m_axis_tdata[WORD_W-1:0];
            got.len = m_axis_tdata[WORD_W +: PLEN_W];
            got.app = m_axis_tuser;
            if (pending_checks.size() == 0) begin
                $display("%0t: unexpected transfer word=%h appended=%b length=%0d",
                         $time, got.word, got.app, got.len);
                failed = 1'b1;
            end else begin
                exp = pending_checks.pop_front();
                if (got.word !== exp.word || got.app !== exp.app || got.len !== exp.len) begin
                    $display("%0t: expected word=%h appended=%b length=%0d, got word=%h appended=%b length=%0d",
                             $time, exp.word, exp.app, exp.len, got.word, got.app, got.len);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        #(CLK_PERIOD * 1_500_000);
        $display("keyed_packet_check_append test failed");
        $finish;
    end

    initial begin
        int sent;
        int n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[i]) begin
            offer_byte(stim_rows[i].data, stim_rows[i].last, stim_rows[i].typed,
                       stim_rows[i].want);
        end
        wait_results_drained();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_set[ph];
            recv_stall_pct = stall_set[ph];
            sent = 0;
            while (sent < 150) begin
                n = ($urandom_range(19) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
                send_packet(n);
                sent += n;
            end
            wait_results_drained();
        end

        // hold the output side off while single-byte packets keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests = hold_requests + 1;
        repeat (40) send_packet(1);
        wait_results_drained();

        repeat (16) @(posedge i_clk);
        if (!failed) begin
            $display("keyed_packet_check_append test passed");
        end else begin
            $display("keyed_packet_check_append test failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/kpca_pkg.sv
rtl/kpca_mix.sv
rtl/keyed_packet_check_append.sv
sim/testbench.sv
